>>> sv/blpg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blpg_pkg: shared types and codes for the Bresenham line pixel generator
// Input word, output word and the command word passed from the front end to
// the back end through the command queue.
// ----------------------------------------------------------------------------
package blpg_pkg;

	localparam int unsigned COL_W = 9;
	localparam int unsigned ROW_W = 8;
	localparam int unsigned COLOR_W = 8;
	localparam int unsigned ADDR_W = 16;

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_STEP = 1'b1;

	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_POS = 2'd1;
	localparam logic [1:0] DIR_NEG = 2'd3;

	localparam int unsigned CMDQ_DEPTH = 2;

	typedef struct packed {
		logic               action;
		logic [COL_W-1:0]   x_start;
		logic [ROW_W-1:0]   y_start;
		logic [COL_W-1:0]   x_end;
		logic [ROW_W-1:0]   y_end;
		logic [COLOR_W-1:0] line_color;
	} in_word_t;

	typedef struct packed {
		logic [COL_W-1:0]   pixel_x;
		logic [ROW_W-1:0]   pixel_y;
		logic [ADDR_W-1:0]  pixel_address;
		logic [COLOR_W-1:0] pixel_color;
		logic               last_pixel;
	} out_word_t;

	typedef struct packed {
		logic               is_start;
		logic [COL_W-1:0]   x1;
		logic [ROW_W-1:0]   y1;
		logic [1:0]         col_dir;
		logic [1:0]         row_dir;
		logic               col_is_major;
		logic [COL_W-1:0]   major_len;
		logic [COL_W-1:0]   minor_len;
		logic [COLOR_W-1:0] color;
	} cmd_t;

endpackage
`default_nettype wire

>>> sv/blpg_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blpg_front: command decode
// Classifies each input word and, for a start, saturates the endpoints and
// works out spans, directions and the major axis.
// ----------------------------------------------------------------------------
module blpg_front #(
	parameter int unsigned SCREEN_W = 320,
	parameter int unsigned SCREEN_H = 200
) (
	input  wire blpg_pkg::in_word_t in_word,
	output blpg_pkg::cmd_t          cmd
);

	localparam int unsigned X_MAX = SCREEN_W - 1;
	localparam int unsigned Y_MAX = SCREEN_H - 1;

	logic [blpg_pkg::COL_W-1:0] x1, x2, dx;
	logic [blpg_pkg::ROW_W-1:0] y1, y2, dy;
	logic [blpg_pkg::COL_W-1:0] dy_ext;
	logic                       col_major;

	always_comb begin
		// saturate endpoints to the screen
		x1 = (32'(in_word.x_start) > X_MAX) ? blpg_pkg::COL_W'(X_MAX) : in_word.x_start;
		x2 = (32'(in_word.x_end) > X_MAX) ? blpg_pkg::COL_W'(X_MAX) : in_word.x_end;
		y1 = (32'(in_word.y_start) > Y_MAX) ? blpg_pkg::ROW_W'(Y_MAX) : in_word.y_start;
		y2 = (32'(in_word.y_end) > Y_MAX) ? blpg_pkg::ROW_W'(Y_MAX) : in_word.y_end;
		dx = (x2 >= x1) ? (x2 - x1) : (x1 - x2);
		dy = (y2 >= y1) ? (y2 - y1) : (y1 - y2);
		dy_ext = blpg_pkg::COL_W'(dy);
		col_major = (dx >= dy_ext);

		cmd.is_start = (in_word.action == blpg_pkg::ACT_START);
		cmd.x1 = x1;
		cmd.y1 = y1;
		cmd.col_dir = (x2 > x1) ? blpg_pkg::DIR_POS :
			((x2 < x1) ? blpg_pkg::DIR_NEG : blpg_pkg::DIR_NONE);
		cmd.row_dir = (y2 > y1) ? blpg_pkg::DIR_POS :
			((y2 < y1) ? blpg_pkg::DIR_NEG : blpg_pkg::DIR_NONE);
		cmd.col_is_major = col_major;
		cmd.major_len = col_major ? dx : dy_ext;
		cmd.minor_len = col_major ? dy_ext : dx;
		cmd.color = in_word.line_color;
	end

endmodule
`default_nettype wire

>>> sv/blpg_cmdq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blpg_cmdq: command queue
// Small register FIFO between the decode front end and the stepping back end.
// ----------------------------------------------------------------------------
module blpg_cmdq (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  wire blpg_pkg::cmd_t  push_cmd,
	output logic                 not_full,
	input  wire                  pop,
	output logic                 not_empty,
	output blpg_pkg::cmd_t       head_cmd
);

	localparam int unsigned DEPTH = blpg_pkg::CMDQ_DEPTH;
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	blpg_pkg::cmd_t   entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign not_full = (count_q != CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

`ifndef SYNTHESIS
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("cmdq: pop while empty");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> not_full) else $error("cmdq: push while full");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("cmdq: count did not advance");
`endif

endmodule
`default_nettype wire

>>> sv/blpg_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blpg_back: line stepper
// Holds the Bresenham state, emits a pixel per start or active-line step and
// computes the framebuffer address in a second stage for the output register.
// ----------------------------------------------------------------------------
module blpg_back #(
	parameter int unsigned SCREEN_W = 320
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      cmd_valid,
	input  wire blpg_pkg::cmd_t      cmd,
	output logic                     cmd_pop,
	output logic                     out_valid,
	input  wire                      out_ready,
	output blpg_pkg::out_word_t      out_word
);

	localparam int unsigned CW = blpg_pkg::COL_W;
	localparam int unsigned RW = blpg_pkg::ROW_W;

	function automatic logic [CW-1:0] move_col(input logic [CW-1:0] pos, input logic [1:0] dir);
		logic [CW-1:0] r;
		r = pos;
		if (dir == blpg_pkg::DIR_POS) begin
			r = pos + 1'b1;
		end else if (dir == blpg_pkg::DIR_NEG && pos != '0) begin
			r = pos - 1'b1;
		end
		return r;
	endfunction

	function automatic logic [RW-1:0] move_row(input logic [RW-1:0] pos, input logic [1:0] dir);
		logic [RW-1:0] r;
		r = pos;
		if (dir == blpg_pkg::DIR_POS) begin
			r = pos + 1'b1;
		end else if (dir == blpg_pkg::DIR_NEG && pos != '0) begin
			r = pos - 1'b1;
		end
		return r;
	endfunction

	// line state
	logic                         active_q;
	logic [CW-1:0]                col_q;
	logic [RW-1:0]                row_q;
	logic [CW-1:0]                major_q, minor_q, err_q, steps_q;
	logic [1:0]                   col_dir_q, row_dir_q;
	logic                         col_major_q;
	logic [blpg_pkg::COLOR_W-1:0] color_q;

	// pixel stage
	logic                         pix_valid_s1;
	logic [CW-1:0]                pix_x_s1;
	logic [RW-1:0]                pix_y_s1;
	logic [blpg_pkg::COLOR_W-1:0] pix_color_s1;
	logic                         pix_last_s1;

	// output stage
	logic                         out_valid_s2;
	blpg_pkg::out_word_t          out_word_s2;

	logic                        adv_s2, adv_s1;
	logic [CW:0]                 err_sum;
	logic                        minor_move;
	logic [CW-1:0]               err_next, col_next;
	logic [RW-1:0]               row_next;
	logic [blpg_pkg::ADDR_W-1:0] addr_full;

	assign adv_s2 = !out_valid_s2 || out_ready;
	assign adv_s1 = !pix_valid_s1 || adv_s2;
	assign cmd_pop = cmd_valid && adv_s1;

	always_comb begin
		err_sum = {1'b0, err_q} + {1'b0, minor_q};
		minor_move = (err_sum >= {1'b0, major_q});
		err_next = minor_move ? CW'(err_sum - {1'b0, major_q}) : err_sum[CW-1:0];
		col_next = col_q;
		row_next = row_q;
		if (col_major_q) begin
			col_next = move_col(col_q, col_dir_q);
			if (minor_move) begin
				row_next = move_row(row_q, row_dir_q);
			end
		end else begin
			row_next = move_row(row_q, row_dir_q);
			if (minor_move) begin
				col_next = move_col(col_q, col_dir_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			col_q <= '0;
			row_q <= '0;
			major_q <= '0;
			minor_q <= '0;
			err_q <= '0;
			steps_q <= '0;
			col_dir_q <= blpg_pkg::DIR_NONE;
			row_dir_q <= blpg_pkg::DIR_NONE;
			col_major_q <= 1'b0;
			color_q <= '0;
			pix_valid_s1 <= 1'b0;
		end else begin
			if (adv_s1) begin
				pix_valid_s1 <= 1'b0;
			end
			if (cmd_pop) begin
				if (cmd.is_start) begin
					active_q <= (cmd.major_len != '0);
					col_q <= cmd.x1;
					row_q <= cmd.y1;
					major_q <= cmd.major_len;
					minor_q <= cmd.minor_len;
					err_q <= cmd.major_len >> 1;
					steps_q <= cmd.major_len;
					col_dir_q <= cmd.col_dir;
					row_dir_q <= cmd.row_dir;
					col_major_q <= cmd.col_is_major;
					color_q <= cmd.color;
					pix_valid_s1 <= 1'b1;
				end else if (active_q) begin
					col_q <= col_next;
					row_q <= row_next;
					err_q <= err_next;
					steps_q <= steps_q - 1'b1;
					active_q <= (steps_q != CW'(1));
					pix_valid_s1 <= 1'b1;
				end
				// drop a step with no active line
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			if (cmd.is_start) begin
				pix_x_s1 <= cmd.x1;
				pix_y_s1 <= cmd.y1;
				pix_color_s1 <= cmd.color;
				pix_last_s1 <= (cmd.major_len == '0);
			end else begin
				pix_x_s1 <= col_next;
				pix_y_s1 <= row_next;
				pix_color_s1 <= color_q;
				pix_last_s1 <= (steps_q == CW'(1));
			end
		end
	end

	assign addr_full = blpg_pkg::ADDR_W'(32'(pix_y_s1) * 32'(SCREEN_W) + 32'(pix_x_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			out_valid_s2 <= pix_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && pix_valid_s1) begin
			out_word_s2.pixel_x <= pix_x_s1;
			out_word_s2.pixel_y <= pix_y_s1;
			out_word_s2.pixel_address <= addr_full;
			out_word_s2.pixel_color <= pix_color_s1;
			out_word_s2.last_pixel <= pix_last_s1;
		end
	end

	assign out_valid = out_valid_s2;
	assign out_word = out_word_s2;

`ifndef SYNTHESIS
	a_active_has_steps: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (steps_q != '0)) else $error("back: active line with no steps");
	a_err_below_major: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (err_q < major_q)) else $error("back: error term out of range");
	a_start_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop && cmd.is_start) |=> pix_valid_s1)
		else $error("back: start gave no pixel");
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid_s1 && !adv_s1) |=> (pix_valid_s1 && $stable(pix_x_s1)
		&& $stable(pix_y_s1))) else $error("back: stalled pixel changed");
`endif

endmodule
`default_nettype wire

>>> sv/bresenham_line_pixel_generator.sv
// Each word goes through the command queue, pixel stage and output register in turn.
// Throughput: a word per cycle unless out_ready stalls; a step is one add and compare.
// The command queue (two entries) lets input words be taken while output stalls.
// Address row*SCREEN_W+col is formed by a constant multiply in the output stage.
// Reset (arst_n low, asynchronous) clears the queue, the pipeline and the line state.
`default_nettype none
// ----------------------------------------------------------------------------
// bresenham_line_pixel_generator: top level
// Decode front end, command queue and line-stepping back end.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_generator #(
	parameter int unsigned SCREEN_W = 320,
	parameter int unsigned SCREEN_H = 200
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  wire blpg_pkg::in_word_t  in_word,
	output logic                     out_valid,
	input  wire                      out_ready,
	output blpg_pkg::out_word_t      out_word
);

	blpg_pkg::cmd_t dec_cmd, head_cmd;
	logic           q_not_full, q_not_empty, q_pop;

	blpg_front #(
		.SCREEN_W(SCREEN_W),
		.SCREEN_H(SCREEN_H)
	) u_front (
		.in_word(in_word),
		.cmd(dec_cmd)
	);

	assign in_ready = q_not_full;

	blpg_cmdq u_cmdq (
		.clk(clk),
		.arst_n(arst_n),
		.push(in_valid && q_not_full),
		.push_cmd(dec_cmd),
		.not_full(q_not_full),
		.pop(q_pop),
		.not_empty(q_not_empty),
		.head_cmd(head_cmd)
	);

	blpg_back #(
		.SCREEN_W(SCREEN_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(q_not_empty),
		.cmd(head_cmd),
		.cmd_pop(q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word)
	);

endmodule
`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: Bresenham line pixel generator
// Feeds start and step words through the valid/ready input, rasterizes each
// accepted word with an in-bench line stepper and compares every output pixel
// field by field, in phases with random stalls on both sides and one without.
// ----------------------------------------------------------------------------
module testbench;

	localparam int SCREEN_W = 320;
	localparam int SCREEN_H = 200;
	localparam int STALL_LIMIT = 3000;
	localparam int COL_W = blpg_pkg::COL_W;
	localparam int ROW_W = blpg_pkg::ROW_W;
	localparam int COLOR_W = blpg_pkg::COLOR_W;
	localparam int ADDR_W = blpg_pkg::ADDR_W;

	logic clk;
	logic arst_n;
	logic in_valid = 1'b0;
	logic in_ready;
	blpg_pkg::in_word_t in_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	blpg_pkg::out_word_t out_word;

	bresenham_line_pixel_generator #(
		.SCREEN_W(SCREEN_W),
		.SCREEN_H(SCREEN_H)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word)
	);

	blpg_pkg::in_word_t pending_words[$];
	blpg_pkg::out_word_t pixels_due[$];
	int error_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_cycles = 0;

	// generator-side bookkeeping: pixels still owed by the line being queued
	int pixels_planned = 0;
	int plan_left = 0;

	// line stepper state
	logic line_on = 1'b0;
	logic [COL_W-1:0] cur_col = '0;
	logic [ROW_W-1:0] cur_row = '0;
	logic [COL_W-1:0] major_len = '0;
	logic [COL_W-1:0] minor_len = '0;
	logic [COL_W:0] err_acc = '0;
	logic [1:0] col_dir = blpg_pkg::DIR_NONE;
	logic [1:0] row_dir = blpg_pkg::DIR_NONE;
	logic col_major = 1'b0;
	logic [COL_W-1:0] steps_left = '0;
	logic [COLOR_W-1:0] held_color = '0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [COL_W-1:0] col_clamp(logic [COL_W-1:0] v);
		return (v > SCREEN_W - 1) ? COL_W'(SCREEN_W - 1) : v;
	endfunction

	function automatic logic [ROW_W-1:0] row_clamp(logic [ROW_W-1:0] v);
		return (v > SCREEN_H - 1) ? ROW_W'(SCREEN_H - 1) : v;
	endfunction

	function automatic int unsigned nudge(int unsigned pos, logic [1:0] dir);
		if (dir == blpg_pkg::DIR_POS)
			return pos + 1;
		if (dir == blpg_pkg::DIR_NEG && pos > 0)
			return pos - 1;
		return pos;
	endfunction

	function automatic int unsigned span_of(blpg_pkg::in_word_t w);
		int unsigned dx, dy;
		dx = col_clamp(w.x_start) >= col_clamp(w.x_end) ?
			col_clamp(w.x_start) - col_clamp(w.x_end) : col_clamp(w.x_end) - col_clamp(w.x_start);
		dy = row_clamp(w.y_start) >= row_clamp(w.y_end) ?
			row_clamp(w.y_start) - row_clamp(w.y_end) : row_clamp(w.y_end) - row_clamp(w.y_start);
		return (dx >= dy) ? dx : dy;
	endfunction

	function automatic blpg_pkg::out_word_t pixel_at(logic last);
		blpg_pkg::out_word_t p;
		int unsigned addr;
		addr = cur_row * SCREEN_W + cur_col;
		p.pixel_x = cur_col;
		p.pixel_y = cur_row;
		p.pixel_address = addr[ADDR_W-1:0];
		p.pixel_color = held_color;
		p.last_pixel = last;
		return p;
	endfunction

	// Advance the line stepper by one accepted word and queue any pixel it gives.
	task automatic rasterize_word(blpg_pkg::in_word_t w);
		logic [COL_W-1:0] x1, x2, dx, dy;
		logic [ROW_W-1:0] y1, y2;
		x1 = col_clamp(w.x_start);
		x2 = col_clamp(w.x_end);
		y1 = row_clamp(w.y_start);
		y2 = row_clamp(w.y_end);
		if (w.action == blpg_pkg::ACT_START) begin
			dx = (x2 >= x1) ? x2 - x1 : x1 - x2;
			dy = (y2 >= y1) ? COL_W'(y2 - y1) : COL_W'(y1 - y2);
			col_dir = (x2 > x1) ? blpg_pkg::DIR_POS :
				((x2 < x1) ? blpg_pkg::DIR_NEG : blpg_pkg::DIR_NONE);
			row_dir = (y2 > y1) ? blpg_pkg::DIR_POS :
				((y2 < y1) ? blpg_pkg::DIR_NEG : blpg_pkg::DIR_NONE);
			col_major = (dx >= dy);
			major_len = col_major ? dx : dy;
			minor_len = col_major ? dy : dx;
			err_acc = major_len >> 1;
			steps_left = major_len;
			cur_col = x1;
			cur_row = y1;
			held_color = w.line_color;
			line_on = (major_len != 0);
			pixels_due.push_back(pixel_at(major_len == 0));
		end else if (line_on) begin
			err_acc = err_acc + minor_len;
			if (err_acc >= major_len) begin
				err_acc = err_acc - major_len;
				if (col_major)
					cur_row = ROW_W'(nudge(cur_row, row_dir));
				else
					cur_col = COL_W'(nudge(cur_col, col_dir));
			end
			if (col_major)
				cur_col = COL_W'(nudge(cur_col, col_dir));
			else
				cur_row = ROW_W'(nudge(cur_row, row_dir));
			if (steps_left > 0)
				steps_left = steps_left - 1;
			if (steps_left == 0)
				line_on = 1'b0;
			pixels_due.push_back(pixel_at(steps_left == 0));
		end
	endtask

	task automatic report_mismatch(string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic check_field(string name, int unsigned got, int unsigned want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	// queue one word and keep track of how many pixels it will give
	task automatic push_word(blpg_pkg::in_word_t w);
		pending_words.push_back(w);
		if (w.action == blpg_pkg::ACT_START) begin
			plan_left = span_of(w);
			pixels_planned++;
		end else if (plan_left > 0) begin
			plan_left--;
			pixels_planned++;
		end
	endtask

	task automatic push_steps(int n);
		logic [63:0] raw;
		blpg_pkg::in_word_t w;
		repeat (n) begin
			raw = {$urandom, $urandom};
			w = raw[$bits(blpg_pkg::in_word_t)-1:0];
			w.action = blpg_pkg::ACT_STEP;
			push_word(w);
		end
	endtask

	task automatic push_line(int x1, int y1, int x2, int y2, int color, int n);
		blpg_pkg::in_word_t w;
		w = '0;
		w.action = blpg_pkg::ACT_START;
		w.x_start = COL_W'(x1);
		w.y_start = ROW_W'(y1);
		w.x_end = COL_W'(x2);
		w.y_end = ROW_W'(y2);
		w.line_color = COLOR_W'(color);
		push_word(w);
		push_steps(n);
	endtask

	// One random chunk: mostly whole lines, some cut short or overrun, plus noise.
	task automatic push_random_chunk();
		int r, reach, d, x1, y1, x2, y2, major, n;
		logic [63:0] raw;
		blpg_pkg::in_word_t w;
		r = $urandom_range(0, 99);
		if (r < 85) begin
			r = $urandom_range(0, 99);
			reach = (r < 70) ? 12 : ((r < 98) ? 60 : 319);
			x1 = $urandom_range(0, SCREEN_W - 1);
			y1 = $urandom_range(0, SCREEN_H - 1);
			d = $urandom_range(0, reach);
			x2 = $urandom_range(0, 1) ? x1 + d : x1 - d;
			d = $urandom_range(0, reach);
			y2 = $urandom_range(0, 1) ? y1 + d : y1 - d;
			x2 = (x2 < 0) ? 0 : ((x2 > SCREEN_W - 1) ? SCREEN_W - 1 : x2);
			y2 = (y2 < 0) ? 0 : ((y2 > SCREEN_H - 1) ? SCREEN_H - 1 : y2);
			// now and then push an endpoint off screen
			if ($urandom_range(0, 19) == 0)
				x2 = $urandom_range(SCREEN_W, (1 << COL_W) - 1);
			if ($urandom_range(0, 19) == 0)
				y1 = $urandom_range(SCREEN_H, (1 << ROW_W) - 1);
			w = '0;
			w.x_start = COL_W'(x1);
			w.y_start = ROW_W'(y1);
			w.x_end = COL_W'(x2);
			w.y_end = ROW_W'(y2);
			major = span_of(w);
			r = $urandom_range(0, 99);
			if (r < 80)
				n = major;
			else if (r < 90)
				n = major + $urandom_range(1, 3);
			else
				n = $urandom_range(0, major);
			push_line(x1, y1, x2, y2, $urandom_range(0, 255), n);
		end else if (r < 92) begin
			push_steps($urandom_range(1, 3));
		end else begin
			raw = {$urandom, $urandom};
			w = raw[$bits(blpg_pkg::in_word_t)-1:0];
			w.action = blpg_pkg::ACT_START;
			push_word(w);
			push_steps($urandom_range(0, 4));
		end
	endtask

	task automatic run_phase(int send_pct, int recv_pct, int pixel_goal);
		int base;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		base = pixels_planned;
		while (pixels_planned - base < pixel_goal)
			push_random_chunk();
		while (pending_words.size() > 0 || in_valid || pixels_due.size() > 0)
			@(negedge clk);
	endtask

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_word <= '0;
		end else begin
			if (in_valid && in_ready)
				rasterize_word(in_word);
			if (!in_valid || in_ready) begin
				if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_word <= pending_words.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor
	always @(posedge clk or negedge arst_n) begin : pixel_monitor
		blpg_pkg::out_word_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (pixels_due.size() == 0) begin
					report_mismatch($sformatf("unexpected pixel x=%0d y=%0d",
						out_word.pixel_x, out_word.pixel_y));
				end else begin
					want = pixels_due.pop_front();
					check_field("pixel_x", out_word.pixel_x, want.pixel_x);
					check_field("pixel_y", out_word.pixel_y, want.pixel_y);
					check_field("pixel_address", out_word.pixel_address, want.pixel_address);
					check_field("pixel_color", out_word.pixel_color, want.pixel_color);
					check_field("last_pixel", out_word.last_pixel, want.last_pixel);
				end
			end
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// watchdog: count busy cycles with no word moving on either side
	always @(posedge clk) begin
		if (arst_n && ((in_valid && in_ready) || (out_valid && out_ready)))
			stall_cycles <= 0;
		else if (arst_n && (pending_words.size() > 0 || in_valid || pixels_due.size() > 0))
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: step before any line, extremes, restarts, single points, clamping
		push_steps(1);
		push_line(0, 0, 319, 199, 8'hFF, 2);
		push_line(319, 199, 0, 0, 8'h00, 2);
		push_line(511, 255, 511, 255, 8'hAA, 0);
		push_steps(1);
		push_line(5, 5, 5, 5, 8'h55, 0);
		push_line(10, 10, 13, 13, 8'h3C, 4);
		push_line(200, 150, 199, 146, 8'hC3, 4);
		push_line(317, 230, 400, 197, 8'h81, 2);

		run_phase(21, 70, 500);
		run_phase(70, 21, 500);
		run_phase(0, 0, 500);

		// let any stray output show up
		repeat (8) @(negedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
